/* rtl/zc_pkg.sv */
// ----------------------------------------------------------------------------
// zc_pkg: shared types, constants and microprogram of the Zeckendorf codec
//
// Holds the field widths of both channels, the mode codes, the control word
// format and the read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package zc_pkg;

  // Default width of the input value.
  localparam int DEF_VALUE_BITS = 31;

  // Field widths of the configuration port and the result channel.
  localparam int MODE_W = 2;
  localparam int TIDX_W = 6;
  localparam int TERM_W = 31;
  localparam int SUM_W  = 12;

  // Internal term index counter; holds every index up to a 63-bit value.
  localparam int IDX_W = 7;

  // Decimal digit extraction: radix, remainder width, bits per cycle.
  localparam int RADIX    = 10;
  localparam int REM_W    = 4;
  localparam int DIV_BITS = 8;

  // Operating modes held in the mode register.
  typedef enum logic [MODE_W-1:0] {
    MODE_BITS   = 2'd0,
    MODE_TERMS  = 2'd1,
    MODE_DIGITS = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_GROW,
    OP_BIT,
    OP_TERM,
    OP_EMPTY,
    OP_CLR_REM,
    OP_DIV,
    OP_ACCUM,
    OP_SUM
  } op_t;

  // Branch conditions. When the condition holds the step jumps and its
  // operation is skipped.
  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_INPUT,
    C_MODE1,
    C_MODE2,
    C_MODE3,
    C_V_ZERO,
    C_B_GT_V,
    C_IDX_ZERO,
    C_DIV_DONE
  } cond_t;

  // Address of the next step when no branch is taken.
  typedef enum logic [1:0] {
    N_SEQ,
    N_HOLD,
    N_JUMP
  } nxt_t;

  // Microprogram addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] S_FETCH = 4'd0;
  localparam logic [UPC_W-1:0] S_MODE2 = 4'd1;
  localparam logic [UPC_W-1:0] S_MODE3 = 4'd2;
  localparam logic [UPC_W-1:0] S_ZERO  = 4'd3;
  localparam logic [UPC_W-1:0] S_GROW  = 4'd4;
  localparam logic [UPC_W-1:0] S_SPLIT = 4'd5;
  localparam logic [UPC_W-1:0] S_BITS  = 4'd6;
  localparam logic [UPC_W-1:0] S_TERMS = 4'd7;
  localparam logic [UPC_W-1:0] S_EMPTY = 4'd8;
  localparam logic [UPC_W-1:0] S_DIGIT = 4'd9;
  localparam logic [UPC_W-1:0] S_DIV   = 4'd10;
  localparam logic [UPC_W-1:0] S_ACCUM = 4'd11;
  localparam logic [UPC_W-1:0] S_SUM   = 4'd12;

  // One control word of the microprogram.
  typedef struct packed {
    op_t              op;
    cond_t            cond;
    nxt_t             nxt;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic  in_valid;
    mode_t mode;
    logic  v_zero;
    logic  b_gt_v;
    logic  a_le_v;
    logic  idx_zero;
    logic  div_done;
    logic  out_busy;
  } stat_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    logic fetch;
    op_t  op;
  } ctl_t;

  // The microprogram.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: C_NEVER, nxt: N_JUMP, target: S_FETCH};
    unique case (addr)
      // Wait for an input transfer and load the working registers.
      S_FETCH: w = '{op: OP_LOAD,    cond: C_NO_INPUT, nxt: N_SEQ,  target: S_FETCH};
      // Dispatch on mode and on a zero value.
      S_MODE2: w = '{op: OP_NOP,     cond: C_MODE2,    nxt: N_SEQ,  target: S_DIGIT};
      S_MODE3: w = '{op: OP_NOP,     cond: C_MODE3,    nxt: N_SEQ,  target: S_FETCH};
      S_ZERO:  w = '{op: OP_NOP,     cond: C_V_ZERO,   nxt: N_SEQ,  target: S_EMPTY};
      // Climb the weights until the next one exceeds the value.
      S_GROW:  w = '{op: OP_GROW,    cond: C_B_GT_V,   nxt: N_HOLD, target: S_SPLIT};
      S_SPLIT: w = '{op: OP_NOP,     cond: C_MODE1,    nxt: N_SEQ,  target: S_TERMS};
      // Walk back down, one bit or one candidate term per step.
      S_BITS:  w = '{op: OP_BIT,     cond: C_IDX_ZERO, nxt: N_HOLD, target: S_FETCH};
      S_TERMS: w = '{op: OP_TERM,    cond: C_V_ZERO,   nxt: N_HOLD, target: S_FETCH};
      S_EMPTY: w = '{op: OP_EMPTY,   cond: C_NEVER,    nxt: N_JUMP, target: S_FETCH};
      // Decimal digit loop: divide by ten, then accumulate digit times weight.
      S_DIGIT: w = '{op: OP_CLR_REM, cond: C_V_ZERO,   nxt: N_SEQ,  target: S_SUM};
      S_DIV:   w = '{op: OP_DIV,     cond: C_DIV_DONE, nxt: N_HOLD, target: S_ACCUM};
      S_ACCUM: w = '{op: OP_ACCUM,   cond: C_NEVER,    nxt: N_JUMP, target: S_DIGIT};
      S_SUM:   w = '{op: OP_SUM,     cond: C_NEVER,    nxt: N_JUMP, target: S_FETCH};
      default: w = '{op: OP_NOP,     cond: C_NEVER,    nxt: N_JUMP, target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* rtl/zc_if.sv */
// ----------------------------------------------------------------------------
// zc_if: channel interfaces of the Zeckendorf codec
//
// Valid/ready channels; a transfer takes place at a rising clock edge at
// which valid and ready are both high.
// ----------------------------------------------------------------------------
interface zc_in_if #(
  parameter int VALUE_BITS = zc_pkg::DEF_VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface zc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        code_bit;
  logic [zc_pkg::TIDX_W-1:0]   term_index;
  logic [zc_pkg::TERM_W-1:0]   term_value;
  logic [zc_pkg::SUM_W-1:0]    decoded_sum;
  logic                        last;
  logic                        empty_res;

  modport source (
    output valid, output code_bit, output term_index, output term_value,
    output decoded_sum, output last, output empty_res, input ready
  );
  modport sink (
    input valid, input code_bit, input term_index, input term_value,
    input decoded_sum, input last, input empty_res, output ready
  );
endinterface

/* rtl/zc_seq.sv */
// ----------------------------------------------------------------------------
// zc_seq: microprogram sequencer of the Zeckendorf codec
//
// Steps through the control words of the microprogram, evaluates the branch
// condition of each step and issues the datapath operation. Steps that
// produce a result hold while the output register is still occupied.
// ----------------------------------------------------------------------------
module zc_seq (
  input  logic          clk,
  input  logic          rst,
  input  zc_pkg::stat_t stat,
  output zc_pkg::ctl_t  ctl
);
  import zc_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  uword_t           uw;
  logic             cond_hit;
  logic             emits;
  logic             stall;

  // Control word of the current step.
  always_comb uw = ucode(upc);

  // Branch condition.
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_NO_INPUT: cond_hit = !stat.in_valid;
      C_MODE1:    cond_hit = (stat.mode == MODE_TERMS);
      C_MODE2:    cond_hit = (stat.mode == MODE_DIGITS);
      C_MODE3:    cond_hit = (stat.mode == MODE_NONE);
      C_V_ZERO:   cond_hit = stat.v_zero;
      C_B_GT_V:   cond_hit = stat.b_gt_v;
      C_IDX_ZERO: cond_hit = stat.idx_zero;
      C_DIV_DONE: cond_hit = stat.div_done;
      default:    cond_hit = 1'b0;
    endcase
  end

  // A step that writes a result waits until the output register is free.
  always_comb begin
    unique case (uw.op)
      OP_BIT, OP_EMPTY, OP_SUM: emits = 1'b1;
      OP_TERM:                  emits = stat.a_le_v;
      default:                  emits = 1'b0;
    endcase
    stall = emits && stat.out_busy;
  end

  // Next step and issued operation.
  always_comb begin
    ctl.fetch = (upc == S_FETCH);
    ctl.op    = OP_NOP;
    upc_next  = upc;
    if (cond_hit) begin
      upc_next = uw.target;
    end else if (!stall) begin
      ctl.op = uw.op;
      unique case (uw.nxt)
        N_SEQ:   upc_next = upc + 1'b1;
        N_HOLD:  upc_next = upc;
        N_JUMP:  upc_next = uw.target;
        default: upc_next = S_FETCH;
      endcase
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

/* rtl/zeckendorf_codec.sv */
// ----------------------------------------------------------------------------
// zeckendorf_codec: integer to Fibonacci (Zeckendorf) form converter
//
// Input channel 'item' carries one value; output channel 'result' carries
// the results it causes, the final one flagged by last. The mode register
// (cfg_we, cfg_wdata) selects: bits of the greedy Zeckendorf form, most
// significant first; the list of greedy terms (index, value), largest first;
// or the weighted sum of the decimal digits of the value. A zero value in
// the first two modes gives one result flagged empty_res; mode 3 gives none.
// Items are handled one at a time by a microprogram sequencer, which takes
// a new item only once the last one is through; a 31-bit value has at most
// 45 Fibonacci weights up to it. The digit mode divides by ten with a unit
// that retires eight bits a cycle of the value, its width rounded up to a
// multiple of eight.
// A result sits in an output register, so a stalled receiver only holds the
// step that writes the next result; a new item is accepted while the last
// result still waits. Reset clears the mode to 0 and the sequencer to fetch.
// ----------------------------------------------------------------------------
module zeckendorf_codec #(
  parameter int VALUE_BITS = zc_pkg::DEF_VALUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [zc_pkg::MODE_W-1:0] cfg_wdata,
  zc_in_if.sink                     item,
  zc_out_if.source                  result
);
  import zc_pkg::*;

  localparam int AW      = VALUE_BITS + 1;
  localparam int QW      = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_CYC = QW / DIV_BITS;
  localparam int DCNT_W  = $clog2(DIV_CYC + 1);
  localparam logic [REM_W:0] RADIX_X = (REM_W + 1)'(RADIX);

  mode_t              mode;
  stat_t              stat;
  ctl_t               ctl;

  logic [QW-1:0]      v;
  logic [AW-1:0]      a;
  logic [AW-1:0]      b;
  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   sum;
  logic [REM_W-1:0]   r;
  logic [DCNT_W-1:0]  dcnt;

  logic [AW-1:0]      vw;
  logic               a_le_v;
  logic [SUM_W-1:0]   prod;
  logic [REM_W-1:0]   rem_next;
  logic [DIV_BITS-1:0] qbits;
  logic [QW-1:0]      v_div;

  logic               out_valid;
  logic               emit;
  logic               code_bit;
  logic [TIDX_W-1:0]  term_index;
  logic [TERM_W-1:0]  term_value;
  logic [SUM_W-1:0]   decoded_sum;
  logic               last;
  logic               empty_res;
  logic               code_bit_next;
  logic [TIDX_W-1:0]  term_index_next;
  logic [TERM_W-1:0]  term_value_next;
  logic [SUM_W-1:0]   decoded_sum_next;
  logic               last_next;
  logic               empty_res_next;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BITS;
    end else if (cfg_we) begin
      mode <= mode_t'(cfg_wdata);
    end
  end

  // Sequencer.
  zc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Comparisons on the residue; the pad bits above the value stay zero.
  assign vw     = AW'(v);
  assign a_le_v = (a <= vw);

  always_comb begin
    stat.in_valid = item.valid;
    stat.mode     = mode;
    stat.v_zero   = (v == '0);
    stat.b_gt_v   = (b > vw);
    stat.a_le_v   = a_le_v;
    stat.idx_zero = (idx == '0);
    stat.div_done = (dcnt == DCNT_W'(DIV_CYC));
    stat.out_busy = out_valid && !result.ready;
  end

  assign item.ready = ctl.fetch;

  // Divide by ten, eight dividend bits a cycle, most significant first.
  // The quotient bits are shifted in at the bottom, so after a full pass
  // the register holds the quotient and r the decimal digit.
  always_comb begin
    logic [REM_W:0] t;
    logic [REM_W:0] t_sub;
    rem_next = r;
    qbits    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t     = {rem_next, v[QW-1-i]};
      t_sub = t - RADIX_X;
      if (t >= RADIX_X) begin
        rem_next              = t_sub[REM_W-1:0];
        qbits[DIV_BITS-1-i]   = 1'b1;
      end else begin
        rem_next              = t[REM_W-1:0];
        qbits[DIV_BITS-1-i]   = 1'b0;
      end
    end
    v_div = (v << DIV_BITS) | QW'(qbits);
  end

  // Digit times weight, kept to the width of the sum.
  assign prod = SUM_W'(r) * SUM_W'(a);

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        v   <= QW'(item.value);
        a   <= AW'(1);
        b   <= AW'(2);
        idx <= IDX_W'(1);
        sum <= '0;
      end
      OP_GROW: begin
        a   <= b;
        b   <= a + b;
        idx <= idx + 1'b1;
      end
      OP_BIT, OP_TERM: begin
        if (a_le_v) begin
          v <= v - QW'(a);
        end
        a   <= b - a;
        b   <= a;
        idx <= idx - 1'b1;
      end
      OP_CLR_REM: begin
        r    <= '0;
        dcnt <= '0;
      end
      OP_DIV: begin
        v    <= v_div;
        r    <= rem_next;
        dcnt <= dcnt + 1'b1;
      end
      OP_ACCUM: begin
        sum <= sum + prod;
        a   <= b;
        b   <= a + b;
      end
      default: begin
      end
    endcase
  end

  // Result payload for the operation being issued.
  always_comb begin
    emit             = 1'b0;
    code_bit_next    = 1'b0;
    term_index_next  = '0;
    term_value_next  = '0;
    decoded_sum_next = '0;
    last_next        = 1'b0;
    empty_res_next   = 1'b0;
    unique case (ctl.op)
      OP_BIT: begin
        emit          = 1'b1;
        code_bit_next = a_le_v;
        last_next     = (idx == IDX_W'(1));
      end
      OP_TERM: begin
        emit            = a_le_v;
        term_index_next = idx[TIDX_W-1:0];
        term_value_next = TERM_W'(a);
        last_next       = (a == vw);
      end
      OP_EMPTY: begin
        emit           = 1'b1;
        last_next      = 1'b1;
        empty_res_next = 1'b1;
      end
      OP_SUM: begin
        emit             = 1'b1;
        decoded_sum_next = sum;
        last_next        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: filled by an issued result, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_bit    <= code_bit_next;
      term_index  <= term_index_next;
      term_value  <= term_value_next;
      decoded_sum <= decoded_sum_next;
      last        <= last_next;
      empty_res   <= empty_res_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.code_bit    = code_bit;
  assign result.term_index  = term_index;
  assign result.term_value  = term_value;
  assign result.decoded_sum = decoded_sum;
  assign result.last        = last;
  assign result.empty_res   = empty_res;

endmodule
